[src/pwc_pkg.sv]
// Shared types and constants for the prioritized write coalescer
// No dependencies; imported by the controller, the datapath and the top level

package pwc_pkg;

  localparam int NUM_SLOTS    = 9;
  localparam int VALUE_BITS   = 16;
  localparam int SLOT_BITS    = 4;
  localparam int TICK_BITS    = 16;
  localparam int ENABLE_SLOT  = 4;
  localparam int CURRENT_SLOT = 5;

  localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

  // configuration register indexes and reset values
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_SPACING   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_KEEPALIVE     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PRESENT_MASK  = 2'd2;
  localparam logic [TICK_BITS-1:0]    MIN_SPACING_RESET = 16'd10;
  localparam logic [TICK_BITS-1:0]    KEEPALIVE_RESET   = 16'd30;
  localparam logic [NUM_SLOTS-1:0]    PRESENT_RESET     = 9'd251;
  localparam int CFG_DATA_BITS = 16;

  typedef enum logic [2:0] {
    OP_ENQUEUE    = 3'd0,
    OP_TICK       = 3'd1,
    OP_COMPLETE   = 3'd2,
    OP_CONNECT    = 3'd3,
    OP_DISCONNECT = 3'd4
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [SLOT_BITS-1:0]  slot;
    logic [VALUE_BITS-1:0] value;
    logic                  skip_if_same;
    logic                  success;
  } cmd_t;

  typedef struct packed {
    logic                  issue_valid;
    logic [SLOT_BITS-1:0]  issue_slot;
    logic [VALUE_BITS-1:0] issue_value;
    logic                  enabled_flag;
    logic [NUM_SLOTS-1:0]  pending_mask;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_t;

endpackage

[src/pwc_ctrl.sv]
// Controller state machine for the prioritized write coalescer
// Depends on pwc_pkg; sequences load and execute steps of the datapath

module pwc_ctrl import pwc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  output logic  result_valid,
  output ctrl_t ctrl
);

  typedef enum logic {
    IDLE,
    EXEC
  } state_t;

  state_t state;

  assign busy      = (state != IDLE);
  assign ctrl.load = start && (state == IDLE);
  assign ctrl.exec = (state == EXEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      result_valid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          result_valid <= 1'b0;
          if (start) begin
            state <= EXEC;
          end
        end
        EXEC: begin
          // result register is loaded in this cycle, shown in the next
          result_valid <= 1'b1;
          state        <= IDLE;
        end
        default: begin
          state        <= IDLE;
          result_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

[src/pwc_datapath.sv]
// Datapath of the prioritized write coalescer: slot table, timers, issue search
// Depends on pwc_pkg; driven by pwc_ctrl through ctrl_t

module pwc_datapath import pwc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  ctrl_t                    ctrl,
  input  cmd_t                     cmd,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output result_t                  result
);

  // configuration
  logic [TICK_BITS-1:0] min_spacing;
  logic [TICK_BITS-1:0] keepalive;
  logic [NUM_SLOTS-1:0] present;

  // command held for the execute cycle
  cmd_t c;

  // slot table
  logic [NUM_SLOTS-1:0]  pending;
  logic [NUM_SLOTS-1:0]  written_once;
  logic [VALUE_BITS-1:0] request_values [NUM_SLOTS];
  logic [VALUE_BITS-1:0] written_values [NUM_SLOTS];

  logic                  link_up;
  logic                  wbusy;
  logic [SLOT_BITS-1:0]  busy_slot;
  logic [VALUE_BITS-1:0] busy_value;
  // request of the slot in flight was overwritten with a different value
  logic                  dirty;
  logic                  any_done;
  logic [TICK_BITS-1:0]  tsw;
  logic [TICK_BITS-1:0]  tcw;
  logic                  enable_state;

  logic [NUM_SLOTS-1:0]  pending_next;
  logic [NUM_SLOTS-1:0]  written_once_next;
  logic                  link_up_next;
  logic                  wbusy_next;
  logic [SLOT_BITS-1:0]  busy_slot_next;
  logic [VALUE_BITS-1:0] busy_value_next;
  logic                  dirty_next;
  logic                  any_done_next;
  logic [TICK_BITS-1:0]  tsw_next;
  logic [TICK_BITS-1:0]  tcw_next;
  logic                  enable_next;

  logic                  req_we;
  logic                  ka_we;
  logic                  wr_we;
  logic                  issue;
  logic [SLOT_BITS-1:0]  issue_slot;
  logic [VALUE_BITS-1:0] issue_value;

  logic                  slot_ok;
  logic                  skip;
  logic [TICK_BITS-1:0]  tsw_inc;
  logic [TICK_BITS-1:0]  tcw_inc;
  logic                  can_issue;
  logic                  ka_due;
  logic [NUM_SLOTS-1:0]  pend_ka;
  logic [NUM_SLOTS-1:0]  cand;
  logic [NUM_SLOTS-1:0]  below;
  logic                  found;
  logic [SLOT_BITS-1:0]  first;

  assign slot_ok = (c.slot < SLOT_BITS'(NUM_SLOTS));
  assign skip    = c.skip_if_same && written_once[c.slot] &&
                   (written_values[c.slot] == c.value) && !pending[c.slot];
  assign tsw_inc = (tsw == TICK_MAX) ? tsw : tsw + 1'b1;
  assign tcw_inc = (tcw == TICK_MAX) ? tcw : tcw + 1'b1;

  assign can_issue = link_up && !wbusy && !(any_done && (tsw_inc < min_spacing));
  assign ka_due    = can_issue && (keepalive != '0) && written_once[CURRENT_SLOT] &&
                     (tcw_inc >= keepalive);
  assign pend_ka   = pending | (NUM_SLOTS'(ka_due) << CURRENT_SLOT);
  assign cand      = pend_ka & present;

  // first pending present slot; below marks the slots ahead of it
  always_comb begin
    found = 1'b0;
    first = '0;
    below = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (!found) begin
        below[s] = 1'b1;
        if (cand[s]) begin
          found    = 1'b1;
          first    = SLOT_BITS'(s);
          below[s] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    pending_next      = pending;
    written_once_next = written_once;
    link_up_next      = link_up;
    wbusy_next        = wbusy;
    busy_slot_next    = busy_slot;
    busy_value_next   = busy_value;
    dirty_next        = dirty;
    any_done_next     = any_done;
    tsw_next          = tsw;
    tcw_next          = tcw;
    enable_next       = enable_state;
    req_we            = 1'b0;
    ka_we             = 1'b0;
    wr_we             = 1'b0;
    issue             = 1'b0;
    issue_slot        = '0;
    issue_value       = '0;
    unique case (c.op)
      OP_ENQUEUE: begin
        if (slot_ok && !skip) begin
          req_we               = 1'b1;
          pending_next[c.slot] = 1'b1;
          if (wbusy && (c.slot == busy_slot)) begin
            dirty_next = (c.value != busy_value);
          end
        end
      end
      OP_TICK: begin
        tsw_next = tsw_inc;
        tcw_next = tcw_inc;
        if (can_issue) begin
          ka_we = ka_due;
          // absent slots ahead of the winner are dropped, all of them if none wins
          pending_next = pend_ka & ~(~present & below);
          if (found) begin
            issue       = 1'b1;
            issue_slot  = first;
            issue_value = (ka_due && (first == SLOT_BITS'(CURRENT_SLOT))) ?
                          written_values[CURRENT_SLOT] : request_values[first];
            wbusy_next      = 1'b1;
            busy_slot_next  = first;
            busy_value_next = issue_value;
            dirty_next      = 1'b0;
          end
        end
      end
      OP_COMPLETE: begin
        if (wbusy) begin
          wbusy_next    = 1'b0;
          any_done_next = 1'b1;
          tsw_next      = '0;
          if (c.success) begin
            wr_we                            = 1'b1;
            written_once_next[busy_slot]     = 1'b1;
            if (!dirty) begin
              pending_next[busy_slot] = 1'b0;
            end
            if (busy_slot == SLOT_BITS'(CURRENT_SLOT)) begin
              tcw_next = '0;
            end
            if (busy_slot == SLOT_BITS'(ENABLE_SLOT)) begin
              enable_next = (busy_value != '0);
            end
          end
        end
      end
      OP_CONNECT: begin
        link_up_next      = 1'b1;
        pending_next      = '0;
        written_once_next = '0;
        wbusy_next        = 1'b0;
      end
      OP_DISCONNECT: begin
        link_up_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_spacing  <= MIN_SPACING_RESET;
      keepalive    <= KEEPALIVE_RESET;
      present      <= PRESENT_RESET;
      pending      <= '0;
      written_once <= '0;
      link_up      <= 1'b0;
      wbusy        <= 1'b0;
      busy_slot    <= '0;
      busy_value   <= '0;
      dirty        <= 1'b0;
      any_done     <= 1'b0;
      tsw          <= '0;
      tcw          <= TICK_MAX;
      enable_state <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MIN_SPACING:  min_spacing <= TICK_BITS'(cfg_data);
          CFG_KEEPALIVE:    keepalive   <= TICK_BITS'(cfg_data);
          CFG_PRESENT_MASK: present     <= cfg_data[NUM_SLOTS-1:0];
          default: begin
          end
        endcase
      end
      if (ctrl.exec) begin
        pending      <= pending_next;
        written_once <= written_once_next;
        link_up      <= link_up_next;
        wbusy        <= wbusy_next;
        busy_slot    <= busy_slot_next;
        busy_value   <= busy_value_next;
        dirty        <= dirty_next;
        any_done     <= any_done_next;
        tsw          <= tsw_next;
        tcw          <= tcw_next;
        enable_state <= enable_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      c <= cmd;
    end
    if (ctrl.exec) begin
      if (req_we) begin
        request_values[c.slot] <= c.value;
      end
      if (ka_we) begin
        request_values[CURRENT_SLOT] <= written_values[CURRENT_SLOT];
      end
      if (wr_we) begin
        written_values[busy_slot] <= busy_value;
      end
      result.issue_valid  <= issue;
      result.issue_slot   <= issue_slot;
      result.issue_value  <= issue_value;
      result.enabled_flag <= enable_next;
      result.pending_mask <= pending_next;
    end
  end

endmodule

[src/prioritized_write_coalescer_top.sv]
// Prioritized write coalescer: holds one pending register write per slot and
// issues them in fixed priority order, with spacing and a keep-alive re-arm.
//
// Command channel: an item (cmd) is taken at a clock edge with start high and
// busy low. Ops are enqueue, tick, write completion, connect and disconnect.
// Every item gives exactly one result on result, marked by result_valid for a
// single cycle; the receiver has no way to hold it off.
// Each accepted item is held in a command register and executed in the EXEC
// state; result and result_valid are registered at its end. busy is high for
// the one execute cycle, so no new item is taken while one is executing; the
// slot table is read and updated by a single execute step in the datapath.
// Configuration: cfg_valid/cfg_ready write channel, always ready; index 0 is the
// minimum write spacing, 1 the keep-alive interval, 2 the slot present mask.
// Writes are meant for idle periods only.
// Reset (rst, synchronous, active high): link down, nothing pending or in
// flight, spacing 10, keep-alive 30, present mask 251, time since the last
// current-slot write saturated.
// Depends on pwc_pkg, pwc_ctrl and pwc_datapath.

module prioritized_write_coalescer_top import pwc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  cmd_t                     cmd,
  output logic                     result_valid,
  output result_t                  result,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  ctrl_t ctrl;

  assign cfg_ready = 1'b1;

  pwc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .ctrl         (ctrl)
  );

  pwc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .cmd       (cmd),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

endmodule

[dv/tb_prioritized_write_coalescer_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for prioritized_write_coalescer_top: a directed
// opening, then randomized phases over several spacing/keep-alive/mask settings.
// Depends on pwc_pkg and the block's RTL; the expected results come from a local model.

module tb_prioritized_write_coalescer_top;
  import pwc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd = '0;
  logic result_valid;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  prioritized_write_coalescer_top dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .result_valid(result_valid),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // local copy of the coalescer state
  logic [TICK_BITS-1:0]  spacing_cfg;
  logic [TICK_BITS-1:0]  keepalive_cfg;
  logic [NUM_SLOTS-1:0]  present_cfg;
  logic [NUM_SLOTS-1:0]  pend;
  logic [NUM_SLOTS-1:0]  written_once;
  logic [VALUE_BITS-1:0] req_val [NUM_SLOTS];
  logic [VALUE_BITS-1:0] wr_val [NUM_SLOTS];
  logic                  link;
  logic                  in_flight;
  logic [SLOT_BITS-1:0]  flight_slot;
  logic [VALUE_BITS-1:0] flight_val;
  logic                  done_any;
  logic [TICK_BITS-1:0]  since_write;
  logic [TICK_BITS-1:0]  since_current;
  logic                  enable_st;

  cmd_t    cmd_queue[$];
  result_t expected_results[$];
  logic [VALUE_BITS-1:0] last_enq [16];
  int errors = 0;
  int cycles = 0;
  bit took = 1'b0;
  int burst_left = 1;
  int gap_left = 0;

  function automatic void clear_state();
    spacing_cfg = MIN_SPACING_RESET;
    keepalive_cfg = KEEPALIVE_RESET;
    present_cfg = PRESENT_RESET;
    pend = '0;
    written_once = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      req_val[s] = '0;
      wr_val[s] = '0;
    end
    link = 1'b0;
    in_flight = 1'b0;
    flight_slot = '0;
    flight_val = '0;
    done_any = 1'b0;
    since_write = '0;
    since_current = TICK_MAX;
    enable_st = 1'b0;
  endfunction

  function automatic logic [TICK_BITS-1:0] sat_up(logic [TICK_BITS-1:0] t);
    return (t == TICK_MAX) ? t : t + 1'b1;
  endfunction

  function automatic result_t coalesce_step(cmd_t c);
    result_t r;
    logic found;
    int s;
    r = '0;
    found = 1'b0;
    case (c.op)
      OP_ENQUEUE: begin
        if (c.slot < NUM_SLOTS) begin
          if (!(c.skip_if_same && written_once[c.slot] &&
                wr_val[c.slot] == c.value && !pend[c.slot])) begin
            req_val[c.slot] = c.value;
            pend[c.slot] = 1'b1;
          end
        end
      end
      OP_TICK: begin
        since_write = sat_up(since_write);
        since_current = sat_up(since_current);
        if (link && !in_flight && !(done_any && since_write < spacing_cfg)) begin
          // keep-alive re-arm of the charging-current slot
          if (keepalive_cfg != 0 && written_once[CURRENT_SLOT] &&
              since_current >= keepalive_cfg) begin
            req_val[CURRENT_SLOT] = wr_val[CURRENT_SLOT];
            pend[CURRENT_SLOT] = 1'b1;
          end
          for (s = 0; s < NUM_SLOTS; s++) begin
            if (!found && pend[s]) begin
              if (!present_cfg[s]) begin
                pend[s] = 1'b0;
              end else begin
                found = 1'b1;
                in_flight = 1'b1;
                flight_slot = s[SLOT_BITS-1:0];
                flight_val = req_val[s];
              end
            end
          end
        end
      end
      OP_COMPLETE: begin
        if (in_flight) begin
          in_flight = 1'b0;
          done_any = 1'b1;
          since_write = '0;
          if (c.success) begin
            // a request overwritten while in flight stays pending
            if (req_val[flight_slot] == flight_val) pend[flight_slot] = 1'b0;
            wr_val[flight_slot] = flight_val;
            written_once[flight_slot] = 1'b1;
            if (flight_slot == CURRENT_SLOT) since_current = '0;
            if (flight_slot == ENABLE_SLOT) enable_st = (flight_val != 0);
          end
        end
      end
      OP_CONNECT: begin
        link = 1'b1;
        pend = '0;
        written_once = '0;
        in_flight = 1'b0;
      end
      OP_DISCONNECT: begin
        link = 1'b0;
      end
      default: begin
      end
    endcase
    r.issue_valid = found;
    r.issue_slot = found ? flight_slot : '0;
    r.issue_value = found ? flight_val : '0;
    r.enabled_flag = enable_st;
    r.pending_mask = pend;
    return r;
  endfunction

  function automatic cmd_t mk(logic [2:0] op, int slot, logic [VALUE_BITS-1:0] value,
                              logic oic, logic ok);
    cmd_t c;
    c.op = op_t'(op);
    c.slot = slot[SLOT_BITS-1:0];
    c.value = value;
    c.skip_if_same = oic;
    c.success = ok;
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int pick;
    c.slot = SLOT_BITS'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 15)
                                                    : $urandom_range(0, 8));
    case ($urandom_range(0, 5))
      0: c.value = '0;
      1: c.value = '1;
      2: c.value = 16'd1;
      3, 4: c.value = last_enq[c.slot];
      default: c.value = VALUE_BITS'($urandom);
    endcase
    c.skip_if_same = 1'($urandom_range(0, 1));
    c.success = ($urandom_range(0, 4) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 30) c.op = OP_ENQUEUE;
    else if (pick < 75) c.op = OP_TICK;
    else if (pick < 91) c.op = OP_COMPLETE;
    else if (pick < 94) c.op = OP_CONNECT;
    else if (pick < 97) c.op = OP_DISCONNECT;
    else c.op = op_t'(3'($urandom_range(5, 7)));
    if (c.op == OP_ENQUEUE) last_enq[c.slot] = c.value;
    return c;
  endfunction

  task automatic write_setting(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MIN_SPACING:  spacing_cfg = data;
      CFG_KEEPALIVE:    keepalive_cfg = data;
      CFG_PRESENT_MASK: present_cfg = data[NUM_SLOTS-1:0];
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(logic [TICK_BITS-1:0] sp, logic [TICK_BITS-1:0] ka,
                                logic [NUM_SLOTS-1:0] mask);
    write_setting(CFG_MIN_SPACING, sp);
    write_setting(CFG_KEEPALIVE, ka);
    write_setting(CFG_PRESENT_MASK, {7'($urandom), mask});
  endtask

  // hold off until every queued item is taken and every result has come back
  task automatic wait_drained();
    do @(posedge clk); while (cmd_queue.size() != 0 || start || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s at cycle %0d: got %0h, expected %0h", what, cycles, got, want);
    errors++;
  endtask

  // item acceptance and prediction
  always @(posedge clk) begin
    took = start && !busy;
    if (took) expected_results.push_back(coalesce_step(cmd));
  end

  // driver: bursts of items with random gaps
  always @(negedge clk) begin
    if (start && !took) begin
      // item still waiting for the block
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left = gap_left - 1;
    end else if (cmd_queue.size() > 0) begin
      cmd <= cmd_queue.pop_front();
      start <= 1'b1;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      end else begin
        burst_left = burst_left - 1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", result, 0);
      end else begin
        want = expected_results.pop_front();
        if (result.issue_valid !== want.issue_valid)
          report_mismatch("issue_valid", result.issue_valid, want.issue_valid);
        if (result.issue_slot !== want.issue_slot)
          report_mismatch("issue_slot", result.issue_slot, want.issue_slot);
        if (result.issue_value !== want.issue_value)
          report_mismatch("issue_value", result.issue_value, want.issue_value);
        if (result.enabled_flag !== want.enabled_flag)
          report_mismatch("enabled_flag", result.enabled_flag, want.enabled_flag);
        if (result.pending_mask !== want.pending_mask)
          report_mismatch("pending_mask", result.pending_mask, want.pending_mask);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [TICK_BITS-1:0] sp_list [8];
    logic [TICK_BITS-1:0] ka_list [8];
    logic [NUM_SLOTS-1:0] mask_list [8];
    clear_state();
    for (int s = 0; s < 16; s++) last_enq[s] = '0;
    sp_list = '{16'd10, 16'd0, 16'hFFFF, 16'd1, 16'd2, 16'd0, 16'hFFFF, 16'd3};
    ka_list = '{16'd30, 16'd0, 16'hFFFF, 16'd1, 16'd5, 16'hFFFF, 16'd0, 16'd1};
    mask_list = '{9'd251, 9'h1FF, 9'h000, 9'h1FF, 9'($urandom), 9'($urandom),
                  9'h1FF, 9'd251};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed opening: no spacing, short keep-alive
    apply_settings(16'd0, 16'd3, 9'd251);
    cmd_queue.push_back(mk(OP_TICK, 0, 0, 0, 0));          // link down
    cmd_queue.push_back(mk(OP_ENQUEUE, 0, 16'hFFFF, 0, 0)); // enqueue while down
    cmd_queue.push_back(mk(OP_CONNECT, 0, 0, 0, 0));       // clears the table
    cmd_queue.push_back(mk(OP_ENQUEUE, 2, 16'd7, 0, 0));   // absent slot
    cmd_queue.push_back(mk(OP_ENQUEUE, 8, 16'd0, 1, 0));   // absent slot
    cmd_queue.push_back(mk(OP_ENQUEUE, 4, 16'd1, 0, 0));
    cmd_queue.push_back(mk(OP_ENQUEUE, 15, 16'd5, 0, 1));  // out of range
    cmd_queue.push_back(mk(OP_ENQUEUE, 5, 16'hFFFF, 0, 0));
    cmd_queue.push_back(mk(OP_TICK, 0, 0, 0, 0));          // drops absent slot 2, issues 4
    cmd_queue.push_back(mk(OP_ENQUEUE, 4, 16'd0, 0, 0));   // overwrite in flight
    cmd_queue.push_back(mk(OP_COMPLETE, 0, 0, 0, 1));
    cmd_queue.push_back(mk(OP_TICK, 0, 0, 0, 0));
    cmd_queue.push_back(mk(OP_COMPLETE, 0, 0, 0, 0));      // failed write
    cmd_queue.push_back(mk(OP_TICK, 0, 0, 0, 0));          // retry
    cmd_queue.push_back(mk(OP_COMPLETE, 0, 0, 0, 1));
    cmd_queue.push_back(mk(OP_TICK, 0, 0, 0, 0));          // issues current slot
    cmd_queue.push_back(mk(OP_COMPLETE, 0, 0, 0, 1));
    cmd_queue.push_back(mk(OP_ENQUEUE, 5, 16'hFFFF, 1, 0)); // skipped, unchanged
    repeat (3) cmd_queue.push_back(mk(OP_TICK, 0, 0, 0, 0)); // keep-alive re-arm
    cmd_queue.push_back(mk(OP_DISCONNECT, 0, 0, 0, 0));
    cmd_queue.push_back(mk(OP_COMPLETE, 0, 0, 0, 1));      // completes after link drop
    cmd_queue.push_back(mk(OP_COMPLETE, 0, 0, 0, 1));      // nothing in flight
    cmd_queue.push_back(mk(3'd5, 3, 16'hA5A5, 1, 1));
    cmd_queue.push_back(mk(3'd6, 9, 16'h5A5A, 0, 0));
    cmd_queue.push_back(mk(3'd7, 15, 16'hFFFF, 1, 1));
    cmd_queue.push_back(mk(OP_CONNECT, 0, 0, 0, 0));
    cmd_queue.push_back(mk(OP_CONNECT, 0, 0, 0, 0));       // already connected
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      apply_settings(sp_list[p], ka_list[p], mask_list[p]);
      cmd_queue.push_back(mk(OP_CONNECT, 0, 0, 0, 0));
      for (int i = 0; i < PHASE_ITEMS; i++) cmd_queue.push_back(random_cmd());
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
src/pwc_pkg.sv
src/pwc_ctrl.sv
src/pwc_datapath.sv
src/prioritized_write_coalescer_top.sv
dv/tb_prioritized_write_coalescer_top.sv
